// ----- rtl/core/lagrange_basis_and_slope_macros.svh -----
// Assertion helpers for the core module lagrange_basis_and_slope.
`ifndef LAGRANGE_BASIS_AND_SLOPE_MACROS_SVH
`define LAGRANGE_BASIS_AND_SLOPE_MACROS_SVH

// same-cycle implication
`define LBS_ASSERT_IMP(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define LBS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/core/lbs_pkg.sv -----
package lbs_pkg;

   localparam int NODE_W        = 26;
   localparam int DEN_W         = 27;
   localparam int PROD_W        = 64;
   localparam int OUT_W         = 32;
   localparam int ACC_W         = 35;
   localparam int IDX_W         = 3;
   localparam int NODE_REGS     = 7;
   localparam int CNT_W         = 7;
   localparam int MAX_NODES_DEF = 7;
   localparam int FRAC_BITS_DEF = 24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_NEXT,
      ST_TERM,
      ST_DSTART,
      ST_DWAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_SAT   = 2'd1,
      STAT_REP   = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic                    done;
      logic                    sat;
      logic signed [OUT_W-1:0] quo;
   } div_rsp_type;

endpackage

// ----- rtl/core/lbs_divider.sv -----
module lbs_divider
   import lbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [PROD_W-1:0] dividend,
   input  logic signed [DEN_W-1:0]  divisor,
   output div_rsp_type              rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] q_ff, q_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]  dmag_ff, dmag_in;
   logic              neg_ff, neg_in;
   logic [DEN_W:0]    shifted;
   logic              qbit;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff[DEN_W-1:0], q_ff[PROD_W-1]};
      qbit    = (shifted >= {1'b0, dmag_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PROD_W);
         q_in    = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
         dmag_in = divisor[DEN_W-1] ? DEN_W'(-divisor) : DEN_W'(divisor);
         neg_in  = dividend[PROD_W-1] ^ divisor[DEN_W-1];
         rem_in  = '0;
      end else if (busy_ff) begin
         // restoring step, one quotient bit per cycle
         rem_in = qbit ? (shifted - {1'b0, dmag_ff}) : shifted;
         q_in   = {q_ff[PROD_W-2:0], qbit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // truncated quotient magnitude in q_ff; sign and saturate here
   always_comb begin
      rsp.done = done_ff;
      rsp.sat  = 1'b0;
      if (neg_ff) begin
         if (q_ff > PROD_W'(64'h8000_0000)) begin
            rsp.sat = 1'b1;
            rsp.quo = {1'b1, {(OUT_W-1){1'b0}}};
         end else begin
            rsp.quo = OUT_W'(-q_ff[OUT_W-1:0]);
         end
      end else begin
         if (q_ff > PROD_W'(64'h7FFF_FFFF)) begin
            rsp.sat = 1'b1;
            rsp.quo = {1'b0, {(OUT_W-1){1'b1}}};
         end else begin
            rsp.quo = q_ff[OUT_W-1:0];
         end
      end
   end

endmodule

// ----- rtl/core/lagrange_basis_and_slope.sv -----
// Lagrange basis value and slope at a point, signed fixed point.
// Config: csr_we/csr_index/csr_wdata. Index 0 is the node count, 1..7 the nodes.
// Write config only while no transaction is in progress.
// Request: req_tdata carries basis index and point t; one transaction at a time.
// req_tready is high only while idle. One response per request on rsp_tdata.
// An index out of range goes straight to the response, and a repeated node is
// reported after a scan of the node list. Otherwise each factor and each slope
// start term is one pass through a shared 64-step bit-serial divider; with n
// nodes that is (n-1) + (n-1)*(n-1) = n*(n-1) passes, so up to 42 passes for
// seven nodes.
// The response is held in output registers until rsp_tready; the block accepts
// nothing new while the response waits.
// Reset (synchronous, active high) restores the default nodes -1.0 and +1.0,
// node count 2, and drops any transaction in progress.
module lagrange_basis_and_slope
   import lbs_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [25:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] basis_index, [28:3] point, [31:29] zero
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] basis_value, [63:32] basis_slope, [65:64] status, [71:66] zero
   output logic [71:0] rsp_tdata
);

   localparam int NIDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam logic signed [OUT_W-1:0]  ONE    = OUT_W'(1) << FRAC_BITS;
   localparam logic signed [PROD_W-1:0] ONE_SQ = PROD_W'(1) << (2 * FRAC_BITS);
   localparam logic signed [ACC_W-1:0]  S_MAX  = ACC_W'(33'sh0_7FFF_FFFF);
   localparam logic signed [ACC_W-1:0]  S_MIN  = -ACC_W'(33'sh0_8000_0000);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] count_ff;
   logic signed [NODE_W-1:0] nodes_ff [MAX_NODES];

   logic [IDX_W-1:0]  i_ff, i_in, n_ff, n_in, j_ff, j_in, k_ff, k_in;
   logic signed [NODE_W-1:0] t_ff, t_in, xi_ff, xi_in;
   logic signed [OUT_W-1:0]  p_ff, p_in, val_ff, val_in, slope_ff, slope_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] div_a_ff, div_a_in;
   logic signed [DEN_W-1:0]  div_b_ff, div_b_in;
   status_type status_ff, status_in;
   logic val_pass_ff, val_pass_in, sat_ff, sat_in, rep_ff, rep_in;

   logic [IDX_W-1:0]         rd_idx, ncap;
   logic signed [NODE_W-1:0] x_rd;
   logic signed [DEN_W-1:0]  num, den;
   div_rsp_type              div_rsp;

   lbs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_DSTART),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .rsp      (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= IDX_W'(2);
         for (int m = 0; m < MAX_NODES; m++) begin
            nodes_ff[m] <= '0;
         end
         nodes_ff[0] <= -(NODE_W'(1) << FRAC_BITS);
         nodes_ff[1] <= NODE_W'(1) << FRAC_BITS;
      end else if (csr_we) begin
         if (csr_index == 3'd0) begin
            count_ff <= csr_wdata[IDX_W-1:0];
         end else if (32'(csr_index) - 1 < MAX_NODES) begin
            nodes_ff[NIDX_W'(csr_index - 3'd1)] <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff <= i_in;   n_ff <= n_in;   j_ff <= j_in;   k_ff <= k_in;
      t_ff <= t_in;   xi_ff <= xi_in;
      p_ff <= p_in;   val_ff <= val_in; slope_ff <= slope_in;
      acc_ff <= acc_in;
      div_a_ff <= div_a_in; div_b_ff <= div_b_in;
      status_ff <= status_in;
      val_pass_ff <= val_pass_in; sat_ff <= sat_in; rep_ff <= rep_in;
   end

   // single read port on the node file
   always_comb begin
      unique case (state_ff)
         ST_IDLE: rd_idx = req_tdata[IDX_W-1:0];
         ST_TERM: rd_idx = k_ff;
         default: rd_idx = j_ff;
      endcase
   end
   assign x_rd = nodes_ff[rd_idx[NIDX_W-1:0]];
   assign num  = DEN_W'(t_ff) - DEN_W'(x_rd);
   assign den  = DEN_W'(xi_ff) - DEN_W'(x_rd);
   assign ncap = (count_ff > IDX_W'(MAX_NODES)) ? IDX_W'(MAX_NODES) : count_ff;

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; n_in = n_ff; j_in = j_ff; k_in = k_ff;
      t_in = t_ff; xi_in = xi_ff;
      p_in = p_ff; val_in = val_ff; slope_in = slope_ff; acc_in = acc_ff;
      div_a_in = div_a_ff; div_b_in = div_b_ff;
      status_in = status_ff;
      val_pass_in = val_pass_ff; sat_in = sat_ff; rep_in = rep_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               i_in = req_tdata[IDX_W-1:0];
               t_in = req_tdata[IDX_W +: NODE_W];
               n_in = ncap;
               xi_in = x_rd;
               j_in = '0;
               rep_in = 1'b0;
               sat_in = 1'b0;
               acc_in = '0;
               val_in = '0;
               slope_in = '0;
               if (req_tdata[IDX_W-1:0] >= ncap) begin
                  status_in = STAT_RANGE;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (j_ff != i_ff && x_rd == xi_ff) begin
               rep_in = 1'b1;
            end
            if (j_ff == n_ff - IDX_W'(1)) begin
               if (rep_in) begin
                  status_in = STAT_REP;
                  state_in = ST_OUT;
               end else begin
                  p_in = ONE;
                  j_in = '0;
                  val_pass_in = 1'b1;
                  state_in = ST_NEXT;
               end
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_NEXT: begin
            if (j_ff == n_ff) begin
               if (val_pass_ff) begin
                  val_in = p_ff;
                  val_pass_in = 1'b0;
                  k_in = '0;
               end else begin
                  acc_in = acc_ff + ACC_W'(p_ff);
                  k_in = k_ff + IDX_W'(1);
               end
               state_in = ST_TERM;
            end else if (j_ff == i_ff || (!val_pass_ff && j_ff == k_ff)) begin
               j_in = j_ff + IDX_W'(1);
            end else begin
               div_a_in = PROD_W'(p_ff) * PROD_W'(num);
               div_b_in = den;
               j_in = j_ff + IDX_W'(1);
               state_in = ST_DSTART;
            end
         end
         ST_TERM: begin
            if (k_ff == n_ff) begin
               if (acc_ff > S_MAX) begin
                  slope_in = S_MAX[OUT_W-1:0];
                  sat_in = 1'b1;
               end else if (acc_ff < S_MIN) begin
                  slope_in = S_MIN[OUT_W-1:0];
                  sat_in = 1'b1;
               end else begin
                  slope_in = acc_ff[OUT_W-1:0];
               end
               status_in = sat_in ? STAT_SAT : STAT_OK;
               state_in = ST_OUT;
            end else if (k_ff == i_ff) begin
               k_in = k_ff + IDX_W'(1);
            end else begin
               div_a_in = ONE_SQ;
               div_b_in = den;
               j_in = '0;
               state_in = ST_DSTART;
            end
         end
         ST_DSTART: state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (div_rsp.done) begin
               p_in = div_rsp.quo;
               sat_in = sat_ff | div_rsp.sat;
               state_in = ST_NEXT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {6'b0, status_ff, slope_ff, val_ff};

`include "lagrange_basis_and_slope_macros.svh"

   `LBS_ASSERT_IMP(a_one_at_a_time, rsp_tvalid, !req_tready, "request taken while response waits")
   `LBS_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "second request taken")
   `LBS_ASSERT_IMP(a_range_zero, rsp_tvalid && rsp_tdata[65:64] == STAT_RANGE, rsp_tdata[63:0] == 64'd0, "range error with data")
   `LBS_ASSERT_IMP(a_div_idle, state_ff != ST_DWAIT, !div_rsp.done, "divider result outside wait")

endmodule
